>>> design/multi_led_blink_scheduler_top_defines.svh
// ----------------------------------------------------------------------------
// Multi-LED blink scheduler assertion macros
// Shared property shapes for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MULTI_LED_BLINK_SCHEDULER_TOP_DEFINES_SVH
`define MULTI_LED_BLINK_SCHEDULER_TOP_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define MLBS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define MLBS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> design/mlbs_pkg.sv
// ----------------------------------------------------------------------------
// Multi-LED blink scheduler package
// Sizes, item kind codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package mlbs_pkg;

  localparam int LED_COUNT = 16;
  localparam int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_ON     = 3'd1;
  localparam logic [2:0] KIND_OFF    = 3'd2;
  localparam logic [2:0] KIND_TOGGLE = 3'd3;
  localparam logic [2:0] KIND_BLINK  = 3'd4;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef logic [23:0] color_t;
  localparam color_t COLOR_BLACK = 24'd0;

  typedef struct packed {
    logic latch;
    logic exec;
    logic walk_start;
    logic walk_step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic in_tick;
    logic in_bad;
    logic walk_last;
  } sts_t;

endpackage

>>> design/mlbs_ctrl.sv
// ----------------------------------------------------------------------------
// Multi-LED blink scheduler controller
// Sequences command execution, the tick walk over all LEDs and the final flush.
// ----------------------------------------------------------------------------
module mlbs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  mlbs_pkg::sts_t sts,
  output mlbs_pkg::cmd_t cmd,
  output logic          busy
);
  import mlbs_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMD   = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          if (sts.in_tick) begin
            cmd.walk_start = 1'b1;
            state_nxt      = S_WALK;
          end else if (!sts.in_bad) begin
            state_nxt = S_CMD;
          end
        end
      end
      S_CMD: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_last) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> design/mlbs_datapath.sv
// ----------------------------------------------------------------------------
// Multi-LED blink scheduler datapath
// LED color and blink record tables, command execution, walk step and
// one-deep result hold that marks the final result of a tick.
// ----------------------------------------------------------------------------
module mlbs_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  mlbs_pkg::cmd_t      cmd,
  output mlbs_pkg::sts_t      sts,
  input  logic [2:0]          in_kind,
  input  logic [7:0]          in_led_number,
  input  logic [7:0]          in_red,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_blue,
  input  logic [31:0]         in_on_time_ms,
  input  logic [31:0]         in_off_time_ms,
  input  logic [7:0]          in_repeat_count,
  input  logic [31:0]         in_now_ms,
  output logic                out_valid,
  output logic [7:0]          out_led_out,
  output logic [7:0]          out_red_out,
  output logic [7:0]          out_green_out,
  output logic [7:0]          out_blue_out,
  output logic                out_status,
  output logic                out_last
);
  import mlbs_pkg::*;

  color_t      led_color_r   [LED_COUNT];
  logic [31:0] phase_start_r [LED_COUNT];
  logic [31:0] lit_dur_r     [LED_COUNT];
  logic [31:0] dark_dur_r    [LED_COUNT];
  logic [8:0]  remain_r      [LED_COUNT];
  color_t      blink_color_r [LED_COUNT];

  logic [2:0]  kind_r;
  logic [7:0]  num_r;
  color_t      color_r;
  logic [31:0] on_t_r;
  logic [31:0] off_t_r;
  logic [7:0]  reps_r;
  logic [31:0] now_r;

  logic [IDX_W-1:0] walk_idx_r;
  logic             pend_v_r;
  logic [7:0]       pend_led_r;
  color_t           pend_color_r;

  logic             out_valid_r;
  logic [7:0]       out_led_r;
  color_t           out_color_r;
  logic             out_status_r;
  logic             out_last_r;

  logic [7:0]       num_m1;
  logic [IDX_W-1:0] cmd_idx;
  logic [IDX_W-1:0] rd_idx;
  logic             num_ok;
  color_t           cur_color;
  color_t           new_color;
  logic [31:0]      elapsed;
  logic             armed;
  logic             fire_off;
  logic             fire_on;
  logic [7:0]       walk_led;

  always_comb begin
    num_m1    = num_r - 8'd1;
    cmd_idx   = num_m1[IDX_W-1:0];
    num_ok    = (num_r != 8'd0) && (num_r <= 8'(LED_COUNT));
    rd_idx    = cmd.walk_step ? walk_idx_r : cmd_idx;
    cur_color = led_color_r[rd_idx];
    elapsed   = now_r - phase_start_r[rd_idx];
    armed     = (remain_r[rd_idx] != 9'd0);
    fire_off  = armed && (cur_color != COLOR_BLACK) && (elapsed > lit_dur_r[rd_idx]);
    fire_on   = armed && (cur_color == COLOR_BLACK) && (elapsed > dark_dur_r[rd_idx]);
    walk_led  = 8'(walk_idx_r) + 8'd1;
    case (kind_r)
      KIND_ON:     new_color = color_r;
      KIND_OFF:    new_color = COLOR_BLACK;
      KIND_TOGGLE: new_color = (cur_color == COLOR_BLACK) ? color_r : COLOR_BLACK;
      default:     new_color = COLOR_BLACK;
    endcase
  end

  assign sts.in_tick   = (in_kind == KIND_TICK);
  assign sts.in_bad    = (in_kind > KIND_BLINK);
  assign sts.walk_last = (walk_idx_r == IDX_W'(LED_COUNT - 1));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r  <= in_kind;
      num_r   <= in_led_number;
      color_r <= {in_red, in_green, in_blue};
      on_t_r  <= in_on_time_ms;
      off_t_r <= in_off_time_ms;
      reps_r  <= in_repeat_count;
      now_r   <= in_now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        led_color_r[i]   <= COLOR_BLACK;
        phase_start_r[i] <= 32'd0;
        lit_dur_r[i]     <= 32'd0;
        dark_dur_r[i]    <= 32'd0;
        remain_r[i]      <= 9'd0;
        blink_color_r[i] <= COLOR_BLACK;
      end
      walk_idx_r   <= '0;
      pend_v_r     <= 1'b0;
      pend_led_r   <= 8'd0;
      pend_color_r <= COLOR_BLACK;
      out_valid_r  <= 1'b0;
      out_led_r    <= 8'd0;
      out_color_r  <= COLOR_BLACK;
      out_status_r <= STATUS_OK;
      out_last_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cmd.exec) begin
        out_led_r  <= num_r;
        out_last_r <= 1'b1;
        if (!num_ok) begin
          out_valid_r  <= 1'b1;
          out_color_r  <= COLOR_BLACK;
          out_status_r <= STATUS_BAD;
        end else if (kind_r == KIND_BLINK) begin
          phase_start_r[cmd_idx] <= now_r;
          lit_dur_r[cmd_idx]     <= on_t_r;
          dark_dur_r[cmd_idx]    <= off_t_r;
          remain_r[cmd_idx]      <= {1'b0, reps_r} + 9'd1;
          blink_color_r[cmd_idx] <= color_r;
        end else begin
          led_color_r[cmd_idx] <= new_color;
          out_valid_r          <= 1'b1;
          out_color_r          <= new_color;
          out_status_r         <= STATUS_OK;
        end
      end
      if (cmd.walk_start) begin
        walk_idx_r <= '0;
        pend_v_r   <= 1'b0;
      end
      if (cmd.walk_step) begin
        walk_idx_r <= walk_idx_r + IDX_W'(1);
        if (fire_off || fire_on) begin
          phase_start_r[walk_idx_r] <= now_r;
          if (fire_off) begin
            led_color_r[walk_idx_r] <= COLOR_BLACK;
            remain_r[walk_idx_r]    <= remain_r[walk_idx_r] - 9'd1;
            pend_color_r            <= COLOR_BLACK;
          end else begin
            led_color_r[walk_idx_r] <= blink_color_r[walk_idx_r];
            pend_color_r            <= blink_color_r[walk_idx_r];
          end
          pend_led_r <= walk_led;
          pend_v_r   <= 1'b1;
          if (pend_v_r) begin
            out_valid_r  <= 1'b1;
            out_led_r    <= pend_led_r;
            out_color_r  <= pend_color_r;
            out_status_r <= STATUS_OK;
            out_last_r   <= 1'b0;
          end
        end
      end
      if (cmd.flush) begin
        pend_v_r <= 1'b0;
        if (pend_v_r) begin
          out_valid_r  <= 1'b1;
          out_led_r    <= pend_led_r;
          out_color_r  <= pend_color_r;
          out_status_r <= STATUS_OK;
          out_last_r   <= 1'b1;
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_led_out   = out_led_r;
  assign out_red_out   = out_color_r[23:16];
  assign out_green_out = out_color_r[15:8];
  assign out_blue_out  = out_color_r[7:0];
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

endmodule

>>> design/multi_led_blink_scheduler_top.sv
// ----------------------------------------------------------------------------
// Multi-LED blink scheduler, top level
// Command port in, one-cycle result strobes out; controller plus datapath.
//
// An item is taken at a rising edge with start high and busy low. Kinds:
// tick, set on, set off, toggle, start blink; the item carries now_ms.
// Set on, set off, toggle, and start blink with a bad LED number give one
// result, with out_valid registered from the command state that follows the
// accepting edge; busy is high for one cycle, in that command state. Other
// start blink items and unknown kinds give no result.
// A tick walks the LED table one entry per cycle in the walk state and then
// passes through the flush state before it returns to idle. One result is
// held back until the next is found, so out_last marks the final result; a
// tick may give none.
// Results show on out_* for exactly one cycle with out_valid; the receiver
// cannot stall and must take each one.
// Reset (rst_n low, synchronous) blacks out all LEDs and clears all blink
// records; the block is idle the cycle after reset is released.
// ----------------------------------------------------------------------------
`include "multi_led_blink_scheduler_top_defines.svh"

module multi_led_blink_scheduler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_led_number,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [31:0] in_on_time_ms,
  input  logic [31:0] in_off_time_ms,
  input  logic [7:0]  in_repeat_count,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  output logic [7:0]  out_led_out,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_status,
  output logic        out_last
);
  import mlbs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mlbs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  mlbs_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_kind),
    .in_led_number   (in_led_number),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_on_time_ms   (in_on_time_ms),
    .in_off_time_ms  (in_off_time_ms),
    .in_repeat_count (in_repeat_count),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_led_out     (out_led_out),
    .out_red_out     (out_red_out),
    .out_green_out   (out_green_out),
    .out_blue_out    (out_blue_out),
    .out_status      (out_status),
    .out_last        (out_last)
  );

  `MLBS_ASSERT_NEXT(a_known_kind_busy, start && !busy && (in_kind <= KIND_BLINK), busy, "no busy")
  `MLBS_ASSERT_NEXT(a_no_result_after_accept, start && !busy, !out_valid, "early result")
  `MLBS_ASSERT_SAME(a_reject_is_last, out_valid && out_status == STATUS_BAD, out_last, "bad not last")
  `MLBS_ASSERT_SAME(a_walk_is_busy, cmd.walk_step || cmd.exec || cmd.flush, busy, "work while idle")

endmodule

>>> tb/mlbs_checker.sv
// ----------------------------------------------------------------------------
// Multi-LED blink scheduler result checker
// Watches the command and result ports, runs its own copy of the LED table
// and blink records for every accepted item, and compares each result strobe
// field by field with the oldest predicted color write.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mlbs_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_led_number,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [31:0] in_on_time_ms,
  input  logic [31:0] in_off_time_ms,
  input  logic [7:0]  in_repeat_count,
  input  logic [31:0] in_now_ms,
  input  logic        out_valid,
  input  logic [7:0]  out_led_out,
  input  logic [7:0]  out_red_out,
  input  logic [7:0]  out_green_out,
  input  logic [7:0]  out_blue_out,
  input  logic        out_status,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);
  import mlbs_pkg::*;

  typedef struct packed {
    logic [7:0] led;
    color_t     color;
    logic       status;
    logic       last;
  } led_write_t;

  led_write_t  expected_writes[$];
  color_t      led_color   [LED_COUNT];
  color_t      blink_color [LED_COUNT];
  logic [31:0] phase_start [LED_COUNT];
  logic [31:0] lit_ms      [LED_COUNT];
  logic [31:0] dark_ms     [LED_COUNT];
  logic [8:0]  blinks_left [LED_COUNT];

  function automatic void predict_writes(logic [2:0] kind, logic [7:0] led, color_t color,
                                         logic [31:0] on_t, logic [31:0] off_t,
                                         logic [7:0] reps, logic [31:0] now);
    led_write_t  held;
    bit          have_held;
    logic [31:0] elapsed;
    int          idx;
    have_held = 1'b0;
    if (kind == KIND_TICK) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        if (blinks_left[i] != 9'd0) begin
          elapsed = now - phase_start[i];
          if (led_color[i] != COLOR_BLACK) begin
            if (elapsed > lit_ms[i]) begin
              led_color[i] = COLOR_BLACK;
              phase_start[i] = now;
              blinks_left[i] = blinks_left[i] - 9'd1;
              if (have_held) expected_writes.push_back(held);
              held = '{led: 8'(i + 1), color: COLOR_BLACK, status: STATUS_OK, last: 1'b0};
              have_held = 1'b1;
            end
          end else if (elapsed > dark_ms[i]) begin
            led_color[i] = blink_color[i];
            phase_start[i] = now;
            if (have_held) expected_writes.push_back(held);
            held = '{led: 8'(i + 1), color: blink_color[i], status: STATUS_OK, last: 1'b0};
            have_held = 1'b1;
          end
        end
      end
      // mark the final write of the walk
      if (have_held) begin
        held.last = 1'b1;
        expected_writes.push_back(held);
      end
    end else if (kind <= KIND_BLINK) begin
      if (led == 8'd0 || led > LED_COUNT) begin
        expected_writes.push_back('{led: led, color: COLOR_BLACK, status: STATUS_BAD,
                                    last: 1'b1});
      end else begin
        idx = led - 1;
        case (kind)
          KIND_BLINK: begin
            phase_start[idx] = now;
            lit_ms[idx] = on_t;
            dark_ms[idx] = off_t;
            blinks_left[idx] = {1'b0, reps} + 9'd1;
            blink_color[idx] = color;
          end
          KIND_ON: led_color[idx] = color;
          KIND_OFF: led_color[idx] = COLOR_BLACK;
          default: led_color[idx] = (led_color[idx] == COLOR_BLACK) ? color : COLOR_BLACK;
        endcase
        if (kind != KIND_BLINK)
          expected_writes.push_back('{led: led, color: led_color[idx], status: STATUS_OK,
                                      last: 1'b1});
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    led_write_t want;
    if (!rst_n) begin
      expected_writes.delete();
      for (int i = 0; i < LED_COUNT; i++) begin
        led_color[i] = COLOR_BLACK;
        blink_color[i] = COLOR_BLACK;
        phase_start[i] = '0;
        lit_ms[i] = '0;
        dark_ms[i] = '0;
        blinks_left[i] = '0;
      end
      fail_count = 0;
    end else begin
      if (out_valid === 1'b1) begin
        if (expected_writes.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result led %0d rgb %02h%02h%02h status %0d last %0d",
                     $realtime, out_led_out, out_red_out, out_green_out, out_blue_out,
                     out_status, out_last);
        end else begin
          want = expected_writes.pop_front();
          if (out_led_out !== want.led || out_red_out !== want.color[23:16] ||
              out_green_out !== want.color[15:8] || out_blue_out !== want.color[7:0] ||
              out_status !== want.status || out_last !== want.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $write("%0t: result mismatch, expected led %0d rgb %06h status %0d last %0d,",
                     $realtime, want.led, want.color, want.status, want.last);
              $display(" got led %0d rgb %02h%02h%02h status %0d last %0d",
                       out_led_out, out_red_out, out_green_out, out_blue_out,
                       out_status, out_last);
            end
          end
        end
      end
      if (start && !busy)
        predict_writes(in_kind, in_led_number, {in_red, in_green, in_blue}, in_on_time_ms,
                       in_off_time_ms, in_repeat_count, in_now_ms);
    end
    pending = expected_writes.size();
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Multi-LED blink scheduler testbench
// Drives directed commands and ticks (edge LED numbers, bad numbers, unknown
// kinds, black colors, time wrap), then random command mixes built around
// armed blink records and advancing time, under three sender idle patterns.
// The checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import mlbs_pkg::*;

  localparam int ITEMS_PER_PHASE = 107;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        start           = 1'b0;
  logic [2:0]  in_kind         = '0;
  logic [7:0]  in_led_number   = '0;
  logic [7:0]  in_red          = '0;
  logic [7:0]  in_green        = '0;
  logic [7:0]  in_blue         = '0;
  logic [31:0] in_on_time_ms   = '0;
  logic [31:0] in_off_time_ms  = '0;
  logic [7:0]  in_repeat_count = '0;
  logic [31:0] in_now_ms       = '0;
  logic        busy;
  logic        out_valid;
  logic [7:0]  out_led_out;
  logic [7:0]  out_red_out;
  logic [7:0]  out_green_out;
  logic [7:0]  out_blue_out;
  logic        out_status;
  logic        out_last;
  int          fail_count;
  int          pending;
  int          idle_pct;
  logic [31:0] sim_now;

  multi_led_blink_scheduler_top DUT (.*);

  mlbs_checker u_checker (.*);

  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_item(logic [2:0] kind, logic [7:0] led, color_t color,
                           logic [31:0] on_t, logic [31:0] off_t, logic [7:0] reps,
                           logic [31:0] now);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_kind         <= kind;
    in_led_number   <= led;
    {in_red, in_green, in_blue} <= color;
    in_on_time_ms   <= on_t;
    in_off_time_ms  <= off_t;
    in_repeat_count <= reps;
    in_now_ms       <= now;
    do @(posedge clk); while (busy);
  endtask

  // hold off until every predicted result has come out
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_duration();
    int r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(0, 6);
    if (r < 95) return $urandom;
    return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
  endfunction

  task automatic send_random_item(output bit counted);
    int          sel;
    int          r;
    logic [2:0]  kind;
    logic [7:0]  led;
    color_t      color;
    logic [7:0]  reps;
    sel = $urandom_range(99);
    r = $urandom_range(99);
    if (r < 90) led = 8'($urandom_range(1, LED_COUNT));
    else if (r < 94) led = 8'd0;
    else led = 8'($urandom_range(LED_COUNT + 1, 255));
    color = ($urandom_range(9) == 0) ? COLOR_BLACK : color_t'($urandom);
    reps = ($urandom_range(4) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    if (sel < 45) begin
      kind = KIND_TICK;
      r = $urandom_range(99);
      if (r < 2) sim_now = $urandom;
      else if (r < 4) sim_now = 32'hFFFF_FFFF - $urandom_range(0, 20);
      else sim_now = sim_now + $urandom_range(0, 4);
    end else if (sel < 60) kind = KIND_BLINK;
    else if (sel < 70) kind = KIND_ON;
    else if (sel < 78) kind = KIND_OFF;
    else if (sel < 95) kind = KIND_TOGGLE;
    else kind = 3'($urandom_range(KIND_BLINK + 1, 7));
    counted = (kind <= KIND_BLINK);
    send_item(kind, led, color, pick_duration(), pick_duration(), reps, sim_now);
  endtask

  initial begin
    int  done_items;
    bit  counted;
    idle_pct = 38;
    sim_now = 32'd1000;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(KIND_TICK, 8'd7, 24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'd0);
    send_item(KIND_ON, 8'd1, 24'hFFFFFF, 32'd0, 32'd0, 8'd0, 32'd10);
    send_item(KIND_ON, 8'd16, 24'h010203, 32'd0, 32'd0, 8'd0, 32'd11);
    send_item(KIND_OFF, 8'd16, 24'hABCDEF, 32'd0, 32'd0, 8'd0, 32'd12);
    send_item(KIND_TOGGLE, 8'd2, 24'hAA55AA, 32'd0, 32'd0, 8'd0, 32'd13);
    send_item(KIND_TOGGLE, 8'd2, 24'h55AA55, 32'd0, 32'd0, 8'd0, 32'd14);
    send_item(KIND_TOGGLE, 8'd3, COLOR_BLACK, 32'd0, 32'd0, 8'd0, 32'd15);
    send_item(KIND_ON, 8'd0, 24'h123456, 32'd0, 32'd0, 8'd0, 32'd16);
    send_item(KIND_TOGGLE, 8'd17, 24'h123456, 32'd0, 32'd0, 8'd0, 32'd17);
    send_item(KIND_BLINK, 8'd255, 24'hFFFFFF, 32'd1, 32'd1, 8'd1, 32'd18);
    send_item(KIND_OFF, 8'd200, 24'h0F0F0F, 32'd0, 32'd0, 8'd0, 32'd19);
    send_item(3'd5, 8'd1, 24'h111111, 32'd0, 32'd0, 8'd0, 32'd20);
    send_item(3'd6, 8'd2, 24'h222222, 32'd0, 32'd0, 8'd0, 32'd21);
    send_item(3'd7, 8'd3, 24'h333333, 32'd0, 32'd0, 8'd0, 32'd22);
    // lit LED goes dark after its lit time, then its record is spent
    send_item(KIND_BLINK, 8'd1, 24'h00FF00, 32'd2, 32'd1, 8'd0, 32'd100);
    send_item(KIND_TICK, 8'd0, 24'h0, 32'd0, 32'd0, 8'd0, 32'd102);
    send_item(KIND_TICK, 8'd0, 24'h0, 32'd0, 32'd0, 8'd0, 32'd103);
    // black blink color keeps rewriting black
    send_item(KIND_BLINK, 8'd5, COLOR_BLACK, 32'd0, 32'd0, 8'd1, 32'd200);
    send_item(KIND_TICK, 8'd0, 24'h0, 32'd0, 32'd0, 8'd0, 32'd201);
    send_item(KIND_TICK, 8'd0, 24'h0, 32'd0, 32'd0, 8'd0, 32'd202);
    // elapsed time across the wrap, largest durations and count
    send_item(KIND_BLINK, 8'd4, 24'h123456, 32'hFFFF_FFFF, 32'd0, 8'hFF, 32'hFFFF_FFF0);
    send_item(KIND_BLINK, 8'd16, 24'hFF0000, 32'd0, 32'hFFFF_FFFF, 8'd3, 32'hFFFF_FFF1);
    send_item(KIND_TICK, 8'hFF, 24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'd2);
    send_item(KIND_TICK, 8'd0, 24'h0, 32'd0, 32'd0, 8'd0, 32'd3);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 38 : (phase == 1) ? 52 : 0;
      done_items = 0;
      while (done_items < ITEMS_PER_PHASE) begin
        send_random_item(counted);
        if (counted) done_items++;
        if ($urandom_range(49) == 0) drain_results();
      end
      drain_results();
    end

    repeat (LED_COUNT + 4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/mlbs_pkg.sv
design/mlbs_ctrl.sv
design/mlbs_datapath.sv
design/multi_led_blink_scheduler_top.sv
tb/mlbs_checker.sv
tb/tb_top.sv
